@@ hdl/clause_subsume_strengthen_check_assert.svh @@
// Assertion macros shared by the clause subsumption checker RTL.
`ifndef CLAUSE_SUBSUME_STRENGTHEN_CHECK_ASSERT_SVH
`define CLAUSE_SUBSUME_STRENGTHEN_CHECK_ASSERT_SVH
`ifndef ASSERT_OFF
`define CSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clause checker assertion failed");
`define CSC_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("clause checker forbidden condition");
`else
`define CSC_ASSERT(lbl, clk, rst_n, prop)
`define CSC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hdl/csc_pkg.sv @@
// Shared types and constants of the clause subsumption checker.
`default_nettype none
package csc_pkg;
  localparam int MAX_CLAUSE_LEN = 64;
  localparam int LIT_W          = 22;
  localparam int ADDR_W         = $clog2(MAX_CLAUSE_LEN);
  localparam int LEN_W          = $clog2(MAX_CLAUSE_LEN + 1);
  localparam int CMDQ_DEPTH     = 4;
  localparam int CMDQ_PTR_W     = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W     = $clog2(CMDQ_DEPTH + 1);

  localparam logic [1:0] FUNC_LOAD       = 2'd0;
  localparam logic [1:0] FUNC_SUBSET     = 2'd1;
  localparam logic [1:0] FUNC_STRENGTHEN = 2'd2;

  typedef enum logic [1:0] {
    VERD_SUBSUME    = 2'd0,
    VERD_STRENGTHEN = 2'd1,
    VERD_NEITHER    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic             is_load;
    logic             strengthen;
    logic [LIT_W-1:0] lit;
    logic             last;
  } cmd_t;
endpackage
`default_nettype wire

@@ hdl/clause_subsume_strengthen_check.sv @@
// A result is registered for the out_ ports as the deciding B literal leaves the queue.
// Throughput: one item per cycle while no result is held or it is popped; each B literal takes
// one compare against the A literal prefetched through the store's registered read port, with
// write-to-read bypass. A 4-entry command queue separates input decode from the merge engine.
// Reset: rst_n synchronous, active low; clears control state, A store contents stay undefined.
// Top level of the sorted clause subsumption and strengthening checker.
`default_nettype none
module clause_subsume_strengthen_check
  import csc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic [1:0]       in_func,
  input  wire logic [LIT_W-1:0] in_literal,
  input  wire logic             in_last,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic [1:0]            out_verdict,
  output logic [LIT_W-1:0]      out_removed_literal
);
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  csc_front u_front (
    .in_push    (in_push),
    .in_func    (in_func),
    .in_literal (in_literal),
    .in_last    (in_last),
    .in_full    (in_full),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  csc_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  csc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_vld             (!q_empty),
    .cmd                 (q_rdata),
    .cmd_pop             (q_pop),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_verdict         (out_verdict),
    .out_removed_literal (out_removed_literal)
  );
endmodule
`default_nettype wire

@@ hdl/csc_front.sv @@
// Front end: takes input transfers, decodes func and queues commands.
`default_nettype none
module csc_front
  import csc_pkg::*;
(
  input  wire logic             in_push,
  input  wire logic [1:0]       in_func,
  input  wire logic [LIT_W-1:0] in_literal,
  input  wire logic             in_last,
  output logic                  in_full,
  output logic                  q_push,
  output cmd_t                  q_data,
  input  wire logic             q_full
);
  logic keep;

  always_comb begin
    keep            = 1'b1;
    q_data.is_load    = 1'b0;
    q_data.strengthen = 1'b0;
    q_data.lit        = in_literal;
    q_data.last       = in_last;
    unique case (in_func)
      FUNC_LOAD:       q_data.is_load = 1'b1;
      FUNC_SUBSET:     q_data.strengthen = 1'b0;
      FUNC_STRENGTHEN: q_data.strengthen = 1'b1;
      default:         keep = 1'b0;
    endcase
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && keep;
endmodule
`default_nettype wire

@@ hdl/csc_cmd_q.sv @@
// Short command queue between front and back end.
`default_nettype none
module csc_cmd_q
  import csc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);
`include "clause_subsume_strengthen_check_assert.svh"

  cmd_t                  store_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;
  logic                  do_push, do_pop;

  assign full     = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CMDQ_CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_data;
  end

  `CSC_NEVER(q_cnt_over, clk, rst_n, cnt_r > CMDQ_CNT_W'(CMDQ_DEPTH))
  `CSC_ASSERT(q_ptr_gap, clk, rst_n, (wr_ptr_r - rd_ptr_r) == cnt_r[CMDQ_PTR_W-1:0])
endmodule
`default_nettype wire

@@ hdl/csc_back.sv @@
// Back end: clause A store, merge against B literals, result register.
`default_nettype none
module csc_back
  import csc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_vld,
  input  wire cmd_t             cmd,
  output logic                  cmd_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output logic [1:0]            out_verdict,
  output logic [LIT_W-1:0]      out_removed_literal
);
`include "clause_subsume_strengthen_check_assert.svh"

  logic [LIT_W-1:0]  mem [MAX_CLAUSE_LEN];
  logic [LIT_W-1:0]  rd_data_r;
  logic [LEN_W-1:0]  a_len_r, a_len_nxt, eff_len;
  logic [LEN_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic [LIT_W-1:0]  pend_r, pend_nxt;
  logic              found_r, found_nxt;
  logic              decided_r, decided_nxt;
  logic              closed_r, closed_nxt;
  logic              out_vld_r, out_vld_nxt;
  verdict_t          out_verd_r;
  logic [LIT_W-1:0]  out_lit_r;
  logic              fire, taken;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              res_fire;
  verdict_t          res_verd;
  logic [LIT_W-1:0]  res_lit;

  assign taken   = out_pop && out_vld_r;
  assign fire    = cmd_vld && (!out_vld_r || out_pop);
  assign cmd_pop = fire;
  assign eff_len = closed_r ? '0 : a_len_r;
  assign pos_inc = pos_r + LEN_W'(1);
  assign wr_addr = eff_len[ADDR_W-1:0];
  assign rd_addr = pos_nxt[ADDR_W-1:0];

  always_comb begin
    a_len_nxt   = a_len_r;
    closed_nxt  = closed_r;
    pos_nxt     = pos_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    decided_nxt = decided_r;
    wr_en       = 1'b0;
    res_fire    = 1'b0;
    res_verd    = VERD_NEITHER;
    res_lit     = '0;
    if (fire) begin
      if (cmd.is_load) begin
        closed_nxt  = cmd.last;
        pos_nxt     = '0;
        pend_nxt    = '0;
        found_nxt   = 1'b0;
        decided_nxt = 1'b0;
        a_len_nxt   = eff_len;
        if (eff_len < LEN_W'(MAX_CLAUSE_LEN)) begin
          wr_en     = 1'b1;
          a_len_nxt = eff_len + LEN_W'(1);
        end
      end else begin
        closed_nxt = 1'b1;
        if (!decided_r) begin
          if (a_len_r == '0) begin
            res_fire = 1'b1;
            res_verd = VERD_SUBSUME;
          end else if (pos_r >= a_len_r) begin
            res_fire = 1'b1;
          end else if (cmd.strengthen && !found_r &&
                       rd_data_r == (cmd.lit ^ LIT_W'(1))) begin
            found_nxt = 1'b1;
            pend_nxt  = cmd.lit;
            pos_nxt   = pos_inc;
            if (pos_inc == a_len_r) begin
              res_fire = 1'b1;
              res_verd = VERD_STRENGTHEN;
              res_lit  = cmd.lit;
            end
          end else if (rd_data_r < cmd.lit) begin
            res_fire = 1'b1;
          end else if (rd_data_r == cmd.lit) begin
            pos_nxt = pos_inc;
            if (pos_inc == a_len_r) begin
              res_fire = 1'b1;
              if (cmd.strengthen && found_r) begin
                res_verd = VERD_STRENGTHEN;
                res_lit  = pend_r;
              end else begin
                res_verd = VERD_SUBSUME;
              end
            end
          end
          if (res_fire) decided_nxt = 1'b1;
        end
        if (cmd.last) begin
          if (!decided_r && !res_fire) res_fire = 1'b1;
          pos_nxt     = '0;
          pend_nxt    = '0;
          found_nxt   = 1'b0;
          decided_nxt = 1'b0;
        end
      end
    end
    if (res_fire)   out_vld_nxt = 1'b1;
    else if (taken) out_vld_nxt = 1'b0;
    else            out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_len_r   <= '0;
      closed_r  <= 1'b0;
      pos_r     <= '0;
      pend_r    <= '0;
      found_r   <= 1'b0;
      decided_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_len_r   <= a_len_nxt;
      closed_r  <= closed_nxt;
      pos_r     <= pos_nxt;
      pend_r    <= pend_nxt;
      found_r   <= found_nxt;
      decided_r <= decided_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_verd_r <= res_verd;
      out_lit_r  <= res_lit;
    end
  end

  // store: one write port, one registered read port with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.lit;
    rd_data_r <= (wr_en && wr_addr == rd_addr) ? cmd.lit : mem[rd_addr];
  end

  assign out_empty           = !out_vld_r;
  assign out_verdict         = out_verd_r;
  assign out_removed_literal = out_lit_r;

  `CSC_NEVER(pos_past_len, clk, rst_n, pos_r > a_len_r)
  `CSC_NEVER(len_over_max, clk, rst_n, a_len_r > LEN_W'(MAX_CLAUSE_LEN))
  `CSC_ASSERT(found_moves_pos, clk, rst_n, found_r |-> (pos_r != '0))
endmodule
`default_nettype wire

@@ sim/clause_subsume_strengthen_check_test.sv @@
// Self-checking testbench for the sorted clause subsumption and strengthening checker.
`timescale 1ns / 100ps
module clause_subsume_strengthen_check_test;
  import csc_pkg::*;

  localparam logic [1:0]       FUNC_UNUSED  = 2'd3;
  localparam logic [LIT_W-1:0] LIT_MAX      = {LIT_W{1'b1}};
  localparam logic [LIT_W-1:0] LIT_MAX_EVEN = LIT_MAX - 1'b1;
  localparam int               DIR_ROWS     = 24;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_VERDICT,
    ROW_VERDICT
  } row_check_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [LIT_W-1:0] lit;
    logic             last;
    row_check_t       check;
    verdict_t         verdict;
    logic [LIT_W-1:0] removed;
  } dir_row_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [LIT_W-1:0] removed;
  } verdict_rec_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [1:0]       in_func;
  logic [LIT_W-1:0] in_literal;
  logic             in_last;
  logic             out_empty;
  logic             out_pop;
  logic [1:0]       out_verdict;
  logic [LIT_W-1:0] out_removed_literal;

  // predictor state
  logic [LIT_W-1:0] pa_store [MAX_CLAUSE_LEN];
  int               pa_len    = 0;
  int               pa_pos    = 0;
  logic [LIT_W-1:0] p_pending = '0;
  bit               p_found   = 1'b0;
  bit               p_decided = 1'b0;
  bit               p_closed  = 1'b0;

  verdict_rec_t     verdict_queue[$];
  logic [LIT_W-1:0] a_lits[$];
  logic [LIT_W-1:0] b_lits[$];
  int               mismatch_count = 0;
  int               literal_count  = 0;
  int               send_idle      = 0;
  int               pop_idle       = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{FUNC_SUBSET,     0,            1'b0, ROW_VERDICT,    VERD_SUBSUME,    0},
    '{FUNC_SUBSET,     LIT_MAX,      1'b1, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_UNUSED,     LIT_MAX,      1'b1, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_LOAD,       0,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_LOAD,       LIT_MAX_EVEN, 1'b1, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, 1,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, LIT_MAX_EVEN, 1'b1, ROW_VERDICT,    VERD_STRENGTHEN, 1},
    '{FUNC_SUBSET,     0,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_SUBSET,     LIT_MAX_EVEN, 1'b1, ROW_VERDICT,    VERD_SUBSUME,    0},
    '{FUNC_SUBSET,     1,            1'b0, ROW_VERDICT,    VERD_NEITHER,    0},
    '{FUNC_SUBSET,     LIT_MAX,      1'b1, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, 0,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, LIT_MAX,      1'b1, ROW_VERDICT,    VERD_STRENGTHEN, LIT_MAX},
    '{FUNC_SUBSET,     0,            1'b1, ROW_VERDICT,    VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, 1,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_LOAD,       5,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_LOAD,       LIT_MAX,      1'b1, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_SUBSET,     4,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, 4,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_SUBSET,     LIT_MAX,      1'b1, ROW_PREDICT,    VERD_NEITHER,    0},
    '{FUNC_SUBSET,     LIT_MAX,      1'b0, ROW_VERDICT,    VERD_NEITHER,    0},
    '{FUNC_SUBSET,     0,            1'b1, ROW_NO_VERDICT, VERD_NEITHER,    0},
    '{FUNC_STRENGTHEN, 5,            1'b1, ROW_PREDICT,    VERD_NEITHER,    0},
    '{FUNC_UNUSED,     0,            1'b0, ROW_NO_VERDICT, VERD_NEITHER,    0}
  };

  clause_subsume_strengthen_check u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_func             (in_func),
    .in_literal          (in_literal),
    .in_last             (in_last),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_verdict         (out_verdict),
    .out_removed_literal (out_removed_literal)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("clause_subsume_strengthen_check_test failed");
    $finish;
  end

  function automatic bit predict_verdict(input logic [1:0] func, input logic [LIT_W-1:0] lit,
                                         input logic last, output verdict_t verdict,
                                         output logic [LIT_W-1:0] removed);
    bit               hit;
    bit               strengthen;
    logic [LIT_W-1:0] a;
    hit     = 1'b0;
    verdict = VERD_NEITHER;
    removed = '0;
    if (func == FUNC_UNUSED) return 1'b0;
    if (func == FUNC_LOAD) begin
      if (p_closed) begin
        pa_len   = 0;
        p_closed = 1'b0;
      end
      pa_pos    = 0;
      p_pending = '0;
      p_found   = 1'b0;
      p_decided = 1'b0;
      if (pa_len < MAX_CLAUSE_LEN) begin
        pa_store[pa_len] = lit;
        pa_len++;
      end
      if (last) p_closed = 1'b1;
      return 1'b0;
    end
    p_closed   = 1'b1;
    strengthen = (func == FUNC_STRENGTHEN);
    if (!p_decided) begin
      if (pa_len == 0) begin
        hit     = 1'b1;
        verdict = VERD_SUBSUME;
      end else if (pa_pos >= pa_len) begin
        hit = 1'b1;
      end else begin
        a = pa_store[pa_pos];
        if (strengthen && !p_found && a == {lit[LIT_W-1:1], ~lit[0]}) begin
          p_found   = 1'b1;
          p_pending = lit;
          pa_pos++;
          if (pa_pos == pa_len) begin
            hit     = 1'b1;
            verdict = VERD_STRENGTHEN;
            removed = p_pending;
          end
        end else if (a < lit) begin
          hit = 1'b1;
        end else if (a == lit) begin
          pa_pos++;
          if (pa_pos == pa_len) begin
            hit = 1'b1;
            if (strengthen && p_found) begin
              verdict = VERD_STRENGTHEN;
              removed = p_pending;
            end else begin
              verdict = VERD_SUBSUME;
            end
          end
        end
      end
      if (hit) p_decided = 1'b1;
    end
    if (last) begin
      if (!p_decided) begin
        hit     = 1'b1;
        verdict = VERD_NEITHER;
        removed = '0;
      end
      pa_pos    = 0;
      p_pending = '0;
      p_found   = 1'b0;
      p_decided = 1'b0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(negedge clk) out_pop <= ($urandom_range(99) >= pop_idle);

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (verdict_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict %0d", out_verdict));
      end else begin
        if (out_verdict != verdict_queue[0].verdict)
          report_mismatch($sformatf("verdict %0d, expected %0d", out_verdict,
                                    verdict_queue[0].verdict));
        if (out_removed_literal != verdict_queue[0].removed)
          report_mismatch($sformatf("removed literal %0h, expected %0h",
                                    out_removed_literal, verdict_queue[0].removed));
        void'(verdict_queue.pop_front());
      end
    end
  end

  task automatic send_item(input logic [1:0] func, input logic [LIT_W-1:0] lit,
                           input logic last, input row_check_t check = ROW_PREDICT,
                           input verdict_t verdict = VERD_NEITHER,
                           input logic [LIT_W-1:0] removed = '0);
    bit               gap;
    bit               hit;
    verdict_t         p_verdict;
    logic [LIT_W-1:0] p_removed;
    verdict_rec_t     rec;
    do begin
      @(negedge clk);
      gap = ($urandom_range(99) < send_idle);
      if (gap) in_push <= 1'b0;
    end while (gap);
    in_push    <= 1'b1;
    in_func    <= func;
    in_literal <= lit;
    in_last    <= last;
    do @(posedge clk); while (in_full);
    hit = predict_verdict(func, lit, last, p_verdict, p_removed);
    case (check)
      ROW_PREDICT: begin
        if (hit) begin
          rec.verdict = p_verdict;
          rec.removed = p_removed;
          verdict_queue.insert(verdict_queue.size(), rec);
        end
      end
      ROW_VERDICT: begin
        rec.verdict = verdict;
        rec.removed = removed;
        verdict_queue.insert(verdict_queue.size(), rec);
      end
      default: ;
    endcase
    if (func != FUNC_UNUSED) literal_count++;
  endtask

  // transfer pause until every pending verdict is out
  task automatic drain;
    @(negedge clk);
    in_push <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk);
  endtask

  task automatic insert_b(input logic [LIT_W-1:0] lit);
    int i;
    i = 0;
    while (i < b_lits.size() && b_lits[i] < lit) i++;
    if (i == b_lits.size() || b_lits[i] != lit) b_lits.insert(i, lit);
  endtask

  function automatic logic [LIT_W-1:0] rand_lit();
    int r;
    r = $urandom_range(99);
    if (r < 20) return LIT_W'($urandom_range(0, 63));
    if (r < 35) return LIT_MAX - LIT_W'($urandom_range(0, 63));
    return LIT_W'($urandom_range(0, LIT_MAX));
  endfunction

  task automatic run_random(input int quota);
    int               stop_at;
    int               len;
    int               r;
    int               idx;
    int               cut;
    logic [1:0]       mode;
    logic [1:0]       f;
    logic [LIT_W-1:0] lit;
    stop_at = literal_count + quota;
    while (literal_count < stop_at) begin
      if ($urandom_range(99) < 80) begin
        r = $urandom_range(99);
        if (r < 4) len = $urandom_range(MAX_CLAUSE_LEN, MAX_CLAUSE_LEN + 3);
        else if (r < 8) len = $urandom_range(MAX_CLAUSE_LEN - 1, MAX_CLAUSE_LEN);
        else len = $urandom_range(1, 6);
        b_lits.delete();
        repeat (len) insert_b(rand_lit());
        a_lits = b_lits;
        foreach (a_lits[i])
          send_item(FUNC_LOAD, a_lits[i], i == a_lits.size() - 1 && $urandom_range(9) != 0);
        while (a_lits.size() > MAX_CLAUSE_LEN) void'(a_lits.pop_back());
        repeat ($urandom_range(1, 4)) begin
          b_lits = a_lits;
          r = $urandom_range(3);
          idx = $urandom_range(0, a_lits.size() - 1);
          if (r == 1) begin
            lit = b_lits[idx];
            b_lits.delete(idx);
            insert_b({lit[LIT_W-1:1], ~lit[0]});
          end else if (r == 2) begin
            b_lits.delete(idx);
          end else if (r == 3) begin
            b_lits.delete();
            repeat ($urandom_range(1, 6)) insert_b(rand_lit());
          end
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(1)) insert_b(rand_lit());
            else insert_b(a_lits[$urandom_range(0, a_lits.size() - 1)] +
                          LIT_W'($urandom_range(1, 3)));
          end
          if (b_lits.size() == 0) insert_b(rand_lit());
          mode = (r == 1 || $urandom_range(1)) ? FUNC_STRENGTHEN : FUNC_SUBSET;
          cut  = ($urandom_range(19) == 0) ? $urandom_range(0, b_lits.size() - 1)
                                            : b_lits.size();
          foreach (b_lits[j]) begin
            if (j == cut) break;
            if ($urandom_range(32) == 0)
              send_item(FUNC_UNUSED, rand_lit(), 1'($urandom_range(1)));
            f = mode;
            if ($urandom_range(9) == 0)
              f = (mode == FUNC_SUBSET) ? FUNC_STRENGTHEN : FUNC_SUBSET;
            send_item(f, b_lits[j], j == b_lits.size() - 1);
          end
          if (cut != b_lits.size()) break;
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(2'($urandom_range(0, 3)), rand_lit(), $urandom_range(2) == 0);
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_func    = FUNC_LOAD;
    in_literal = '0;
    in_last    = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 29;
    pop_idle  = 75;
    foreach (dir_table[i])
      send_item(dir_table[i].func, dir_table[i].lit, dir_table[i].last, dir_table[i].check,
                dir_table[i].verdict, dir_table[i].removed);
    drain();
    run_random(210);
    drain();

    send_idle = 75;
    pop_idle  = 29;
    run_random(210);
    drain();

    send_idle = 0;
    pop_idle  = 0;
    run_random(210);
    drain();

    wait_cycles = 0;
    while (wait_cycles < 10) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (mismatch_count == 0 && verdict_queue.size() == 0) begin
      $display("clause_subsume_strengthen_check_test passed");
    end else begin
      $display("clause_subsume_strengthen_check_test failed");
    end
    $finish;
  end

endmodule
